// File: src/sfxc_pkg.sv
// ----------------------------------------------------------------------------
// sfxc_pkg
// Shared types, constants and helpers for the framed XOR checksum checker.
// ----------------------------------------------------------------------------
package sfxc_pkg;

    localparam int BYTE_W             = 8;
    localparam int MS_W               = 16;
    localparam int LEN_W              = 7;
    localparam int IN_TDATA_W         = 8;
    localparam int OUT_TDATA_W        = 32;
    localparam int FRAME_CAPACITY_DEF = 128;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QUEUE_AW           = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW           = $clog2(QUEUE_DEPTH + 1);
    localparam int MIN_FRAME          = 9;
    localparam int XOR_START          = 4;

    localparam logic [MS_W-1:0]   TIMEOUT_RESET = 16'd1000;
    localparam logic [MS_W-1:0]   MS_MAX        = 16'hFFFF;
    localparam logic [BYTE_W-1:0] CH_STX        = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX        = 8'h03;
    localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
    localparam logic [BYTE_W-1:0] SEP_MARK      = 8'h2A;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_STX   = 2'd1,
        K_CLOSE = 2'd2,
        K_DATA  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_NOT_HEX  = 2'd2,
        ST_MISMATCH = 2'd3
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic   valid;
        t_item  item;
    } t_qport;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// File: src/sfxc_front.sv
// ----------------------------------------------------------------------------
// sfxc_front
// Input side: takes transfers and sorts them into ticks, starts, line ends
// and stored characters.
// ----------------------------------------------------------------------------
module sfxc_front (
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [sfxc_pkg::BYTE_W-1:0]    i_s_axis_tdata,
    input  logic                           i_s_axis_tuser,
    input  logic                           i_q_full,
    output sfxc_pkg::t_qport               o_push
);
    import sfxc_pkg::*;

    t_kind             kind;
    logic [BYTE_W-1:0] data;

    always_comb begin
        kind = K_DATA;
        data = i_s_axis_tdata;
        if (i_s_axis_tuser == CMD_TICK) begin
            kind = K_TICK;
        end else if (i_s_axis_tdata == CH_STX) begin
            kind = K_STX;
        end else if (i_s_axis_tdata == CH_CR || i_s_axis_tdata == CH_LF) begin
            kind = K_CLOSE;
        end else if (i_s_axis_tdata == CH_ETX) begin
            data = SEP_MARK;
        end
    end

    assign o_s_axis_tready   = !i_q_full;
    assign o_push.valid      = i_s_axis_tvalid && !i_q_full;
    assign o_push.item.kind  = kind;
    assign o_push.item.data  = data;

endmodule

// File: src/sfxc_queue.sv
// ----------------------------------------------------------------------------
// sfxc_queue
// Short queue between the input side and the frame engine.
// ----------------------------------------------------------------------------
module sfxc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfxc_pkg::t_qport  i_push,
    output logic              o_full,
    output sfxc_pkg::t_qport  o_head,
    input  logic              i_pop
);
    import sfxc_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push.valid, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    assign o_full       = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

// File: src/sfxc_back.sv
// ----------------------------------------------------------------------------
// sfxc_back
// Frame engine: tick counter, delay line, running XOR and verdict register.
// ----------------------------------------------------------------------------
module sfxc_back #(
    parameter int FRAME_CAPACITY = sfxc_pkg::FRAME_CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sfxc_pkg::MS_W-1:0]         i_cfg_wr_data,
    input  sfxc_pkg::t_qport                  i_head,
    output logic                              o_pop,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [sfxc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import sfxc_pkg::*;

    localparam int CNT_W = $clog2(FRAME_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(FRAME_CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(MIN_FRAME);
    localparam logic [CNT_W-1:0] CNT_XOR   = CNT_W'(XOR_START);
    localparam int PAD_W = OUT_TDATA_W - 2 - LEN_W - 2 * BYTE_W;

    logic [MS_W-1:0]   r_timeout;
    logic              r_in_frame, n_in_frame;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [MS_W-1:0]   r_elapsed, n_elapsed;
    logic [BYTE_W-1:0] r_tail0, n_tail0;
    logic [BYTE_W-1:0] r_tail1, n_tail1;
    logic [BYTE_W-1:0] r_tail2, n_tail2;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0] r_comp, n_comp;
    logic [BYTE_W-1:0] r_recv, n_recv;
    logic [4:0]        hex_hi, hex_lo;
    logic [BYTE_W-1:0] recv_val;

    assign hex_hi   = hex_digit(r_tail1);
    assign hex_lo   = hex_digit(r_tail2);
    assign recv_val = {hex_hi[3:0], hex_lo[3:0]};

    assign o_pop = i_head.valid &&
                   (i_head.item.kind != K_CLOSE || !r_out_valid || i_m_axis_tready);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_elapsed   = r_elapsed;
        n_tail0     = r_tail0;
        n_tail1     = r_tail1;
        n_tail2     = r_tail2;
        n_xor       = r_xor;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_status    = r_status;
        n_len       = r_len;
        n_comp      = r_comp;
        n_recv      = r_recv;
        if (o_pop) begin
            case (i_head.item.kind)
                K_TICK: begin
                    if (r_elapsed != MS_MAX) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                end
                K_STX: begin
                    n_in_frame = 1'b1;
                    n_count    = CNT_W'(1);
                    n_elapsed  = '0;
                    n_tail0    = '0;
                    n_tail1    = '0;
                    n_tail2    = '0;
                    n_xor      = '0;
                end
                K_CLOSE: begin
                    if (r_in_frame) begin
                        if (r_elapsed <= r_timeout) begin
                            n_out_valid = 1'b1;
                            n_len       = LEN_W'(r_count);
                            n_comp      = '0;
                            n_recv      = '0;
                            if (r_count < CNT_MIN) begin
                                n_status = ST_SHORT;
                            end else begin
                                n_comp = r_xor;
                                if (!hex_hi[4] || !hex_lo[4]) begin
                                    n_status = ST_NOT_HEX;
                                end else begin
                                    n_recv   = recv_val;
                                    n_status = (recv_val == r_xor) ? ST_OK : ST_MISMATCH;
                                end
                            end
                        end
                        n_in_frame = 1'b0;
                        n_count    = '0;
                        n_tail0    = '0;
                        n_tail1    = '0;
                        n_tail2    = '0;
                        n_xor      = '0;
                    end
                end
                default: begin
                    if (r_in_frame) begin
                        if (r_elapsed > r_timeout) begin
                            n_in_frame = 1'b0;
                            n_count    = '0;
                            n_tail0    = '0;
                            n_tail1    = '0;
                            n_tail2    = '0;
                            n_xor      = '0;
                        end else if (r_count < CNT_LAST) begin
                            if (r_count >= CNT_XOR) begin
                                n_xor = r_xor ^ r_tail0;
                            end
                            n_tail0 = r_tail1;
                            n_tail1 = r_tail2;
                            n_tail2 = i_head.item.data;
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_elapsed   <= '0;
            r_tail0     <= '0;
            r_tail1     <= '0;
            r_tail2     <= '0;
            r_xor       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            r_in_frame  <= n_in_frame;
            r_count     <= n_count;
            r_elapsed   <= n_elapsed;
            r_tail0     <= n_tail0;
            r_tail1     <= n_tail1;
            r_tail2     <= n_tail2;
            r_xor       <= n_xor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_len    <= n_len;
        r_comp   <= n_comp;
        r_recv   <= n_recv;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_recv, r_comp, r_len, r_status};

endmodule

// File: src/stx_frame_xor_checksum_checker.sv
// ----------------------------------------------------------------------------
// stx_frame_xor_checksum_checker
// Checks STX-started, CR/LF-terminated lines against their trailing two-digit
// hex XOR checksum; a per-frame millisecond timeout drops stale frames.
//
//   port group   dir  payload
//   s_axis       in   tdata[7:0] data_byte; tuser[0] command (1 = ms tick)
//   m_axis       out  tdata[1:0] status, [8:2] frame_length,
//                     [16:9] computed_checksum, [24:17] received_checksum
//   cfg          in   wr_data[15:0] timeout_ms, written when wr_en is high
//
// One transfer per cycle while the queue has room; each byte passes the
// classifier, a two-entry queue and the frame engine, so a verdict is
// registered in the verdict register once its CR or LF has been queued and
// every item ahead of it in the queue has been taken. A pending verdict
// stalls only the next line end; other transfers keep flowing until the queue
// fills. Reset is synchronous, active low, and restores timeout_ms to 1000.
// ----------------------------------------------------------------------------
module stx_frame_xor_checksum_checker #(
    parameter int FRAME_CAPACITY = sfxc_pkg::FRAME_CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [sfxc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // [7:0] data_byte
    input  logic                              i_s_axis_tuser,  // [0] command
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [1:0] status, [8:2] frame_length, [16:9] computed_checksum,
    // [24:17] received_checksum, [31:25] zero
    output logic [sfxc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [sfxc_pkg::MS_W-1:0]         i_cfg_wr_data
);
    import sfxc_pkg::*;

    t_qport push;
    t_qport head;
    logic   q_full;
    logic   pop;

    sfxc_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_push          (push)
    );

    sfxc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    sfxc_back #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// File: tb/frame_verdict_checker.sv
// ----------------------------------------------------------------------------
// frame_verdict_checker
// Follows the serial and tick transfers into the framed XOR checksum checker,
// rebuilds each frame's verdict from its own copy of the frame state and the
// timeout register, and matches every verdict transfer against the oldest
// outstanding one, field by field. Mismatches are counted for the testbench.
// ----------------------------------------------------------------------------
module frame_verdict_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [sfxc_pkg::IN_TDATA_W-1:0]  i_s_tdata,     // [7:0] data_byte
    input  logic                             i_s_tuser,     // [0] command
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // [1:0] status, [8:2] frame_length, [16:9] computed_checksum,
    // [24:17] received_checksum, [31:25] zero
    input  logic [sfxc_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_cfg_wr_en,
    input  logic [sfxc_pkg::MS_W-1:0]        i_cfg_wr_data,
    output int                               o_fail_count,
    output int                               o_verdicts_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfxc_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] computed;
        logic [BYTE_W-1:0] received;
    } t_verdict;

    logic              framing;
    logic [LEN_W-1:0]  char_count;
    logic [MS_W-1:0]   ms_elapsed;
    logic [MS_W-1:0]   timeout_ms;
    logic [BYTE_W-1:0] tail [3];
    logic [BYTE_W-1:0] xor_acc;
    t_verdict          verdict_q [$];
    int                fails;

    function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        return -1;
    endfunction

    task automatic clear_line();
        framing    = 1'b0;
        char_count = '0;
        tail[0]    = '0;
        tail[1]    = '0;
        tail[2]    = '0;
        xor_acc    = '0;
    endtask

    task automatic track_transfer(input logic cmd, input logic [BYTE_W-1:0] b);
        t_verdict v;
        int       hi;
        int       lo;
        if (cmd == CMD_TICK) begin
            if (ms_elapsed != MS_MAX) ms_elapsed++;
        end else if (b == CH_STX) begin
            clear_line();
            framing    = 1'b1;
            char_count = LEN_W'(1);
            ms_elapsed = '0;
        end else if (framing) begin
            if (ms_elapsed > timeout_ms) begin
                // stale frame: drop it and swallow this byte
                clear_line();
            end else if (b == CH_CR || b == CH_LF) begin
                v.length   = char_count;
                v.computed = '0;
                v.received = '0;
                if (char_count < MIN_FRAME) begin
                    v.status = ST_SHORT;
                end else begin
                    hi         = hex_nibble(tail[1]);
                    lo         = hex_nibble(tail[2]);
                    v.computed = xor_acc;
                    if (hi < 0 || lo < 0) begin
                        v.status = ST_NOT_HEX;
                    end else begin
                        v.received = BYTE_W'(hi * 16 + lo);
                        if (v.received == xor_acc) begin
                            v.status = ST_OK;
                        end else begin
                            v.status = ST_MISMATCH;
                        end
                    end
                end
                verdict_q.push_back(v);
                clear_line();
            end else if (char_count < FRAME_CAPACITY_DEF - 1) begin
                // advance the delay line; from XOR_START on, the oldest char enters the XOR
                if (char_count >= XOR_START) xor_acc ^= tail[0];
                tail[0] = tail[1];
                tail[1] = tail[2];
                tail[2] = (b == CH_ETX) ? SEP_MARK : b;
                char_count++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic compare_verdict(input logic [OUT_TDATA_W-1:0] word);
        t_verdict want;
        if (verdict_q.size() == 0) begin
            $error("verdict transfer with none outstanding: tdata %h", word);
            fails++;
        end else begin
            want = verdict_q.pop_front();
            check_field("status", 32'(want.status), 32'(word[1:0]));
            check_field("frame_length", 32'(want.length), 32'(word[8:2]));
            check_field("computed_checksum", 32'(want.computed), 32'(word[16:9]));
            check_field("received_checksum", 32'(want.received), 32'(word[24:17]));
            check_field("padding", 32'd0, 32'(word[31:25]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timeout_ms = TIMEOUT_RESET;
            ms_elapsed = '0;
            clear_line();
            verdict_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) compare_verdict(i_m_tdata);
            if (i_cfg_wr_en) timeout_ms = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) track_transfer(i_s_tuser, i_s_tdata);
        end
        o_verdicts_due <= verdict_q.size();
        o_fail_count   <= fails;
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the framed XOR checksum checker. Sends a few fixed
// lines, then random lines under a series of timeout settings (both extremes
// included) with ticks mixed in. Both stream sides stall at random, except
// for one phase that runs with no idling at all.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfxc_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PCT      = 31;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 60;
    localparam int KIND_OVERFLOW = 87;
    localparam int KIND_RANDOM   = -1;

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   s_tuser     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic [MS_W-1:0]        cfg_wr_data = '0;
    int                     fail_count;
    int                     verdicts_due;
    bit                     calm        = 1'b0;
    int                     items_sent  = 0;
    logic [MS_W-1:0]        timeout_plan [8];
    logic [BYTE_W-1:0]      opening [26];

    stx_frame_xor_checksum_checker dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    frame_verdict_checker u_verdict_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_fail_count   (fail_count),
        .o_verdicts_due (verdicts_due)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // hold tvalid high across back-to-back transfers; drop it only to idle
    task automatic push(input logic cmd, input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic set_timeout(input logic [MS_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_char(input logic [BYTE_W-1:0] c, input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct) begin
            repeat ($urandom_range(1, 3)) push(CMD_TICK, BYTE_W'($urandom_range(0, 255)));
        end
        push(CMD_BYTE, c);
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return BYTE_W'("0") + BYTE_W'(n);
        return (lower ? BYTE_W'("a") : BYTE_W'("A")) + BYTE_W'(n - 4'd10);
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex_char();
        logic [BYTE_W-1:0] c;
        do begin
            c = BYTE_W'($urandom_range(0, 255));
        end while (c == CH_STX || c == CH_CR || c == CH_LF ||
                   (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
                   (c >= "a" && c <= "f"));
        return c;
    endfunction

    // one line: mostly well-formed, some bad or non-hex checksums, short, overflowing,
    // unterminated lines and raw noise
    task automatic send_line(input int tick_pct, input int kind);
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] sep;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        int                pick;
        int                n;
        int                tail_len;
        pick = (kind < 0) ? int'($urandom_range(0, 99)) : kind;
        sum  = '0;
        if (pick >= 89 && pick < 95) begin
            repeat ($urandom_range(1, 6)) begin
                push(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
            end
        end else begin
            if (pick < 70) begin
                n = ($urandom_range(0, 9) == 0) ? 5 : int'($urandom_range(5, 16));
            end else if (pick < 78) begin
                n = $urandom_range(5, 12);
            end else if (pick < 86) begin
                n = $urandom_range(0, 4);
            end else if (pick < 89) begin
                n = $urandom_range(120, 150);
            end else begin
                n = $urandom_range(0, 10);
            end
            repeat (n) begin
                if ($urandom_range(0, 99) < 88) begin
                    c = BYTE_W'($urandom_range(32, 126));
                end else if ($urandom_range(0, 2) == 0) begin
                    c = CH_ETX;
                end else begin
                    do begin
                        c = BYTE_W'($urandom_range(0, 255));
                    end while (c == CH_STX || c == CH_CR || c == CH_LF);
                end
                body.push_back(c);
                sum ^= (c == CH_ETX) ? SEP_MARK : c;
            end
            sep = ($urandom_range(0, 3) == 0) ? CH_ETX : SEP_MARK;
            hi  = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
            lo  = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
            if (pick >= 60 && pick < 70) begin
                if ($urandom_range(0, 1) == 1) begin
                    hi = hex_char(sum[7:4] ^ 4'($urandom_range(1, 15)), 1'b0);
                end else begin
                    lo = hex_char(sum[3:0] ^ 4'($urandom_range(1, 15)), 1'b1);
                end
            end else if (pick >= 70 && pick < 78) begin
                case ($urandom_range(0, 2))
                    0: hi = non_hex_char();
                    1: lo = non_hex_char();
                    default: begin
                        hi = non_hex_char();
                        lo = non_hex_char();
                    end
                endcase
            end
            tail_len = (pick >= 78 && pick < 86) ? int'($urandom_range(0, 3)) : 3;
            push(CMD_BYTE, CH_STX);
            foreach (body[i]) send_char(body[i], tick_pct);
            if (pick < 95) begin
                if (tail_len > 0) send_char(sep, tick_pct);
                if (tail_len > 1) send_char(hi, tick_pct);
                if (tail_len > 2) send_char(lo, tick_pct);
                send_char(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF, tick_pct);
            end
        end
    endtask

    initial begin
        int phase_start;
        int tick_pct;
        opening = '{CH_CR,
                    CH_STX, "A", CH_LF,
                    CH_STX, "Q", CH_STX, CH_ETX, 8'hFF, 8'h80, "z", "0",
                    CH_ETX, "1", "f", CH_CR,
                    CH_STX, "G", "P", "S", "0", "9", "*", "G", "1", CH_LF};
        timeout_plan = '{16'd0, MS_MAX, 16'd4, 16'd12, 16'd1, 16'd40, TIMEOUT_RESET,
                         MS_W'($urandom_range(2, 300))};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[i]) push(CMD_BYTE, opening[i]);

        foreach (timeout_plan[p]) begin
            calm = (p == 6);
            set_timeout(timeout_plan[p]);
            tick_pct = $urandom_range(3, 12);
            if (p == 1 || p == 6) send_line(tick_pct, KIND_OVERFLOW);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_line(tick_pct, KIND_RANDOM);
        end
        calm = 1'b0;

        set_timeout(TIMEOUT_RESET);
        repeat (6) send_line(5, KIND_RANDOM);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: stx_frame_xor_checksum_checker.f
src/sfxc_pkg.sv
src/sfxc_front.sv
src/sfxc_queue.sv
src/sfxc_back.sv
src/stx_frame_xor_checksum_checker.sv
tb/frame_verdict_checker.sv
tb/tb.sv
